### src/salc_pkg.sv
package salc_pkg;

  // Width of one line's recency rank.
  localparam int RANK_W = 4;
  // Largest rank, and so the largest number of ways that can be in use.
  localparam int RANK_MAX = 15;

  // Widths of the configuration registers and of the write port.
  localparam int SET_BITS_W = 3;
  localparam int OFFSET_W   = 6;
  localparam int WAYS_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Enough bits for the sum of the index width and the offset width.
  localparam int SHIFT_W = 7;

  // Width of the running totals.
  localparam int CNT_W = 32;

  // Request type field.
  localparam int REQ_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd2;

  // Request type codes; any code from modify upward makes two passes.
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // latch a new request and decode its address
    logic rd_en;     // read the set's row from the arrays
    logic load_row;  // move the read row into the working registers
    logic find;      // pick the hit, fill or victim way
    logic update;    // apply ranks, fill and counters for one pass
    logic second;    // the pass being run is the second one of a modify
    logic write;     // write the row back and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic modify;    // the held request needs a second pass
    logic out_busy;  // the result register holds an unaccepted result
  } sts_t;

endpackage

### src/set_assoc_lru_cache_model.sv
// Set-associative cache with LRU replacement, one request at a time.
// A new request is taken only once the last one is written back; the set row goes
// through one read, one find and update per pass, and one write of the row arrays, which
// also loads the result register and waits while that register holds an unaccepted result.
// Reset clears the valid and rank state of every set at once through per-set flags,
// clears the totals and resets the configuration; the block takes requests right after reset.
module set_assoc_lru_cache_model #(
  parameter int MAX_SETS   = 64,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [salc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [salc_pkg::REQ_W-1:0]           req_type_i,
  input  logic [63:0]                          access_address_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 first_hit_o,
  output logic                                 evicted_o,
  output logic                                 second_hit_o,
  output logic [salc_pkg::CNT_W-1:0]           hit_total_o,
  output logic [salc_pkg::CNT_W-1:0]           miss_total_o,
  output logic [salc_pkg::CNT_W-1:0]           eviction_total_o
);

  salc_pkg::cmd_t cmd;
  salc_pkg::sts_t sts;

  // Configuration writes are taken in every cycle.
  assign cfg_ready_o = 1'b1;

  salc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  salc_dp #(
    .MAX_SETS  (MAX_SETS),
    .MAX_WAYS  (MAX_WAYS),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_type_i),
    .access_address_i(access_address_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .first_hit_o     (first_hit_o),
    .evicted_o       (evicted_o),
    .second_hit_o    (second_hit_o),
    .hit_total_o     (hit_total_o),
    .miss_total_o    (miss_total_o),
    .eviction_total_o(eviction_total_o)
  );

endmodule

### src/salc_ram.sv
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   wr_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                       wr_data_i,
  input  logic                                   rd_en_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                       rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Single write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/salc_ctrl.sv
module salc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  salc_pkg::sts_t   sts_i,
  output salc_pkg::cmd_t   cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_LOAD   = 6'b000100,
    ST_FIND   = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_WRITE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   pass_q, pass_d;

  // A new request is taken only when no earlier one is in the arrays.
  assign in_stall_o = (state_q != ST_IDLE);

  // Sequence one request: read the set, run one or two passes, write back.
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    cmd_o   = '0;
    cmd_o.second = pass_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          pass_d       = 1'b0;
          state_d      = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load_row = 1'b1;
        state_d        = ST_FIND;
      end
      ST_FIND: begin
        cmd_o.find = 1'b1;
        state_d    = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        if (sts_i.modify && !pass_q) begin
          pass_d  = 1'b1;
          state_d = ST_FIND;
        end else begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!sts_i.out_busy) begin
          cmd_o.write = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

endmodule

### src/salc_dp.sv
module salc_dp #(
  parameter int MAX_SETS   = 64,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  salc_pkg::cmd_t                       cmd_i,
  output salc_pkg::sts_t                       sts_o,
  input  logic                                 cfg_valid_i,
  input  logic [salc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [salc_pkg::REQ_W-1:0]           req_type_i,
  input  logic [63:0]                          access_address_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 first_hit_o,
  output logic                                 evicted_o,
  output logic                                 second_hit_o,
  output logic [salc_pkg::CNT_W-1:0]           hit_total_o,
  output logic [salc_pkg::CNT_W-1:0]           miss_total_o,
  output logic [salc_pkg::CNT_W-1:0]           eviction_total_o
);

  localparam int RANK_W  = salc_pkg::RANK_W;
  localparam int CNT_W   = salc_pkg::CNT_W;
  localparam int SET_AW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_AW  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  // Widest set index whose set count still fits in the arrays.
  localparam int SET_LOG = $clog2(MAX_SETS + 1) - 1;
  localparam int EMAX    = (MAX_WAYS < salc_pkg::RANK_MAX) ? MAX_WAYS : salc_pkg::RANK_MAX;
  localparam int META_W  = 1 + RANK_W;
  localparam int LVLS    = $clog2(MAX_WAYS);
  localparam int WP2     = 1 << LVLS;

  // Configuration registers.
  logic [salc_pkg::SET_BITS_W-1:0] set_bits_q;
  logic [salc_pkg::OFFSET_W-1:0]   offset_q;
  logic [salc_pkg::WAYS_W-1:0]     ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= '0;
      offset_q   <= '0;
      ways_q     <= salc_pkg::WAYS_W'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        salc_pkg::CFG_SET_BITS: set_bits_q <= cfg_data_i[salc_pkg::SET_BITS_W-1:0];
        salc_pkg::CFG_OFFSET:   offset_q   <= cfg_data_i[salc_pkg::OFFSET_W-1:0];
        salc_pkg::CFG_WAYS:     ways_q     <= cfg_data_i[salc_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Address decode under the current geometry.
  logic [salc_pkg::SET_BITS_W-1:0] s_eff;
  logic [RANK_W-1:0]               e_d;
  logic [ADDR_WIDTH-1:0]           addr;
  logic [ADDR_WIDTH-1:0]           addr_sh;
  logic [SET_AW-1:0]               set_mask;
  logic [SET_AW-1:0]               set_d;
  logic [ADDR_WIDTH-1:0]           tag_d;
  logic [salc_pkg::SHIFT_W-1:0]    tag_shift;

  always_comb begin
    if (int'(set_bits_q) > SET_LOG) begin
      s_eff = salc_pkg::SET_BITS_W'(SET_LOG);
    end else begin
      s_eff = set_bits_q;
    end
    if (ways_q == '0) begin
      e_d = RANK_W'(1);
    end else if (int'(ways_q) > EMAX) begin
      e_d = RANK_W'(EMAX);
    end else begin
      e_d = ways_q;
    end
    addr    = access_address_i[ADDR_WIDTH-1:0];
    addr_sh = addr >> offset_q;
    for (int i = 0; i < SET_AW; i++) begin
      set_mask[i] = (i < int'(s_eff));
    end
    set_d     = addr_sh[SET_AW-1:0] & set_mask;
    tag_shift = salc_pkg::SHIFT_W'(s_eff) + salc_pkg::SHIFT_W'(offset_q);
    tag_d     = addr >> tag_shift;
  end

  // Request registers.
  logic [SET_AW-1:0]          set_q;
  logic [ADDR_WIDTH-1:0]      tag_q;
  logic [salc_pkg::REQ_W-1:0] type_q;
  logic [RANK_W-1:0]          e_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      set_q  <= set_d;
      tag_q  <= tag_d;
      type_q <= req_type_i;
      e_q    <= e_d;
    end
  end

  assign sts_o.modify = (type_q >= salc_pkg::REQ_MODIFY);

  // Row storage: ranks and valid bits in one array, tags in another.
  logic [MAX_WAYS*META_W-1:0]     meta_rd, meta_wr;
  logic [MAX_WAYS*ADDR_WIDTH-1:0] tag_rd, tag_wr;
  logic [MAX_SETS-1:0]            row_written_q;

  salc_ram #(
    .WIDTH(MAX_WAYS*META_W),
    .DEPTH(MAX_SETS)
  ) u_meta_ram (
    .clk_i    (clk_i),
    .wr_en_i  (cmd_i.write),
    .wr_addr_i(set_q),
    .wr_data_i(meta_wr),
    .rd_en_i  (cmd_i.rd_en),
    .rd_addr_i(set_q),
    .rd_data_o(meta_rd)
  );

  salc_ram #(
    .WIDTH(MAX_WAYS*ADDR_WIDTH),
    .DEPTH(MAX_SETS)
  ) u_tag_ram (
    .clk_i    (clk_i),
    .wr_en_i  (cmd_i.write),
    .wr_addr_i(set_q),
    .wr_data_i(tag_wr),
    .rd_en_i  (cmd_i.rd_en),
    .rd_addr_i(set_q),
    .rd_data_o(tag_rd)
  );

  // A row never written since reset reads as all invalid with rank zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_written_q <= '0;
    end else if (cmd_i.write) begin
      row_written_q[set_q] <= 1'b1;
    end
  end

  // Working copy of the set's row.
  logic                  valid_q [MAX_WAYS];
  logic [RANK_W-1:0]     rank_q  [MAX_WAYS];
  logic [ADDR_WIDTH-1:0] line_q  [MAX_WAYS];

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      meta_wr[w*META_W +: META_W]         = {valid_q[w], rank_q[w]};
      tag_wr[w*ADDR_WIDTH +: ADDR_WIDTH]  = line_q[w];
    end
  end

  // Way selection: first hit, else first invalid way, else lowest rank.
  logic [MAX_WAYS-1:0] in_use, match, inval;
  logic                hit_any, inval_any;
  logic [WAY_AW-1:0]   hit_way, inval_way;
  logic [RANK_W:0]     key [LVLS+1][WP2];
  logic [WAY_AW-1:0]   kidx [LVLS+1][WP2];
  logic [WAY_AW-1:0]   pick_way;
  logic                pick_evict;

  always_comb begin
    hit_way   = '0;
    inval_way = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (w < int'(e_q));
      match[w]  = in_use[w] && valid_q[w] && (line_q[w] == tag_q);
      inval[w]  = in_use[w] && !valid_q[w];
    end
    hit_any   = |match;
    inval_any = |inval;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_AW'(w);
      end
      if (inval[w]) begin
        inval_way = WAY_AW'(w);
      end
    end
    // Minimum rank over the ways in use; ties keep the lower way.
    for (int i = 0; i < WP2; i++) begin
      kidx[0][i] = WAY_AW'(i);
      if (i < MAX_WAYS && i < int'(e_q)) begin
        key[0][i] = {1'b0, rank_q[i]};
      end else begin
        key[0][i] = '1;
      end
    end
    for (int l = 0; l < LVLS; l++) begin
      for (int i = 0; i < WP2; i++) begin
        if (i < (WP2 >> (l + 1))) begin
          if (key[l][2*i+1] < key[l][2*i]) begin
            key[l+1][i]  = key[l][2*i+1];
            kidx[l+1][i] = kidx[l][2*i+1];
          end else begin
            key[l+1][i]  = key[l][2*i];
            kidx[l+1][i] = kidx[l][2*i];
          end
        end else begin
          key[l+1][i]  = '1;
          kidx[l+1][i] = '0;
        end
      end
    end
    if (hit_any) begin
      pick_way   = hit_way;
      pick_evict = 1'b0;
    end else if (inval_any) begin
      pick_way   = inval_way;
      pick_evict = 1'b0;
    end else begin
      pick_way   = kidx[LVLS][0];
      pick_evict = 1'b1;
    end
  end

  logic              sel_hit_q, sel_evict_q;
  logic [WAY_AW-1:0] sel_way_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.find) begin
      sel_hit_q   <= hit_any;
      sel_evict_q <= pick_evict;
      sel_way_q   <= pick_way;
    end
  end

  // Row load and the per-pass update: every higher rank drops by one,
  // the touched way becomes most recent, and a miss fills the way.
  logic [RANK_W-1:0] touch_rank;
  assign touch_rank = rank_q[sel_way_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_row) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (row_written_q[set_q]) begin
          valid_q[w] <= meta_rd[w*META_W + RANK_W];
          rank_q[w]  <= meta_rd[w*META_W +: RANK_W];
        end else begin
          valid_q[w] <= 1'b0;
          rank_q[w]  <= '0;
        end
        line_q[w] <= tag_rd[w*ADDR_WIDTH +: ADDR_WIDTH];
      end
    end else if (cmd_i.update) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        if (w == int'(sel_way_q)) begin
          rank_q[w] <= e_q;
          if (!sel_hit_q) begin
            valid_q[w] <= 1'b1;
            line_q[w]  <= tag_q;
          end
        end else if (in_use[w] && (rank_q[w] > touch_rank)) begin
          rank_q[w] <= rank_q[w] - RANK_W'(1);
        end
      end
    end
  end

  // Running totals, saturating, and the flags of the request in flight.
  logic [CNT_W-1:0] hit_cnt_q, miss_cnt_q, evict_cnt_q;
  logic             first_hit_q, second_hit_q, evicted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
    end else if (cmd_i.update) begin
      if (sel_hit_q) begin
        if (hit_cnt_q != '1) begin
          hit_cnt_q <= hit_cnt_q + CNT_W'(1);
        end
      end else if (miss_cnt_q != '1) begin
        miss_cnt_q <= miss_cnt_q + CNT_W'(1);
      end
      if (sel_evict_q && (evict_cnt_q != '1)) begin
        evict_cnt_q <= evict_cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      first_hit_q  <= 1'b0;
      second_hit_q <= 1'b0;
      evicted_q    <= 1'b0;
    end else if (cmd_i.update) begin
      if (cmd_i.second) begin
        second_hit_q <= sel_hit_q;
      end else begin
        first_hit_q <= sel_hit_q;
      end
      evicted_q <= evicted_q | sel_evict_q;
    end
  end

  // Result register; it frees as soon as the result is taken.
  logic             out_valid_q;
  logic             res_first_q, res_second_q, res_evicted_q;
  logic [CNT_W-1:0] res_hit_q, res_miss_q, res_evict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.write) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      res_first_q   <= first_hit_q;
      res_second_q  <= second_hit_q;
      res_evicted_q <= evicted_q;
      res_hit_q     <= hit_cnt_q;
      res_miss_q    <= miss_cnt_q;
      res_evict_q   <= evict_cnt_q;
    end
  end

  assign sts_o.out_busy   = out_valid_q && out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign first_hit_o      = res_first_q;
  assign evicted_o        = res_evicted_q;
  assign second_hit_o     = res_second_q;
  assign hit_total_o      = res_hit_q;
  assign miss_total_o     = res_miss_q;
  assign eviction_total_o = res_evict_q;

endmodule
